// ===== sv/lifo_pkg.sv =====
// ----------------------------------------------------------------------------
// lifo_pkg
// Shared types and codes for the lifo stack with count and search unit.
// ----------------------------------------------------------------------------
package lifo_pkg;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_COUNT = 2'd2,
        REQ_INDEX = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_POP_EMPTY  = 2'd1;
    localparam logic [1:0] STATUS_PUSH_FULL  = 2'd2;

    localparam logic [4:0] COUNT_MAX = 5'd31;
    localparam logic [4:0] INDEX_MAX = 5'd15;
    localparam logic [4:0] INDEX_NONE = 5'h1f;

endpackage

// ===== sv/lifo_stack_with_count_and_search_unit.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_with_count_and_search_unit
// Bounded stack of signed 32-bit values with match count and top-down search.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries req_type and item_value.
//   Output channel (out_valid / out_stall) carries status, match_count,
//   match_index and store_empty, one result beat per request beat.
//   Push writes the entry memory, and push and pop update the fill level at
//   the accept edge; the result is loaded into the output register in the
//   S_FINISH state. Count and index requests read the entry memory through
//   its single read port, one entry per cycle from the top down.
//   One request is in work at a time; in_stall is high while it runs.
//   A finished result waits in the output register while out_stall is high;
//   the next request may already be accepted, and its result waits until
//   the output register is taken.
//   Reset empties the store and drops any pending result; the entry memory
//   itself is not cleared, entries are only read after they were pushed.
// ----------------------------------------------------------------------------
module lifo_stack_with_count_and_search_unit
    import lifo_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] item_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [4:0]         match_count,
    output logic signed [4:0]  match_index,
    output logic               store_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW > 5) ? LW : 5;
    localparam int PW = (AW > 5) ? AW : 5;

    logic [31:0] mem [DEPTH];
    logic [31:0] mem_q;

    state_t state_reg, state_next;

    logic [LW-1:0] fill_reg;
    logic [LW-1:0] fill_dec;
    req_t          req_reg;
    logic [31:0]   val_reg;
    logic [1:0]    stat_reg;
    logic [LW-1:0] issue_left_reg;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] pos_reg;
    logic          rd_valid_reg;
    logic [AW-1:0] rd_pos_reg;
    logic [LW-1:0] cnt_reg;
    logic          found_reg;
    logic [AW-1:0] hit_pos_reg;
    logic          out_valid_reg;

    logic          accept;
    logic          issue;
    logic          out_load;
    logic          wr_en;
    logic          is_full;
    logic          is_empty;
    req_t          req_in;
    logic          hit;
    logic [CW-1:0] cnt_ext;
    logic [PW-1:0] pos_ext;
    logic [4:0]    count_res;
    logic [4:0]    index_res;

    assign req_in   = req_t'(req_type);
    assign fill_dec = fill_reg - LW'(1);
    assign is_full  = (fill_reg == LW'(DEPTH));
    assign is_empty = (fill_reg == '0);
    assign accept   = in_valid && !in_stall;
    assign wr_en    = accept && (req_in == REQ_PUSH) && !is_full;
    assign hit      = rd_valid_reg && (mem_q == val_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((req_in == REQ_COUNT || req_in == REQ_INDEX) && !is_empty)
                        state_next = S_SCAN;
                    else
                        state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                if (issue_left_reg == '0)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall = 1'b1;
        issue    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:   in_stall = 1'b0;
            S_SCAN:   issue    = (issue_left_reg != '0);
            S_FINISH: out_load = !out_valid_reg || !out_stall;
            default:  in_stall = 1'b1;
        endcase
    end

    // entry memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[fill_reg[AW-1:0]] <= item_value;
        mem_q <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= issue;
            if (accept)
            begin
                if (req_in == REQ_PUSH && !is_full)
                    fill_reg <= fill_reg + LW'(1);
                else if (req_in == REQ_POP && !is_empty)
                    fill_reg <= fill_dec;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // request and scan datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg        <= req_in;
            val_reg        <= item_value;
            issue_left_reg <= fill_reg;
            addr_reg       <= fill_dec[AW-1:0];
            pos_reg        <= '0;
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
            hit_pos_reg    <= '0;
            if (req_in == REQ_PUSH && is_full)
                stat_reg <= STATUS_PUSH_FULL;
            else if (req_in == REQ_POP && is_empty)
                stat_reg <= STATUS_POP_EMPTY;
            else
                stat_reg <= STATUS_OK;
        end
        else
        begin
            if (issue)
            begin
                issue_left_reg <= issue_left_reg - LW'(1);
                addr_reg       <= addr_reg - AW'(1);
                pos_reg        <= pos_reg + AW'(1);
            end
            if (hit)
            begin
                cnt_reg <= cnt_reg + LW'(1);
                if (!found_reg)
                begin
                    found_reg   <= 1'b1;
                    hit_pos_reg <= rd_pos_reg;
                end
            end
        end
        rd_pos_reg <= pos_reg;
    end

    // saturate results to field range
    always_comb
    begin
        cnt_ext = CW'(cnt_reg);
        pos_ext = PW'(hit_pos_reg);
        count_res = (cnt_ext > CW'(COUNT_MAX)) ? COUNT_MAX : cnt_ext[4:0];
        if (!found_reg)
            index_res = INDEX_NONE;
        else
            index_res = (pos_ext > PW'(INDEX_MAX)) ? INDEX_MAX : pos_ext[4:0];
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status      <= stat_reg;
            store_empty <= is_empty;
            match_count <= (req_reg == REQ_COUNT) ? count_res : 5'd0;
            match_index <= (req_reg == REQ_INDEX) ? index_res : 5'd0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
